### design/mlpd_pkg.sv
// Shared types and constants for the dense forward pass unit.
`default_nettype none
package mlpd_pkg;
    localparam int MAX_LAYERS_DEF  = 4;
    localparam int MAX_NEURONS_DEF = 64;
    localparam int FRAC_BITS_DEF   = 8;

    localparam int VAL_W = 16;
    localparam int ACC_W = 48;

    typedef enum logic [2:0] {
        ACT_WR_WEIGHT = 3'd0,
        ACT_WR_BIAS   = 3'd1,
        ACT_WR_ACT    = 3'd2,
        ACT_RUN       = 3'd3,
        ACT_READ      = 3'd4
    } t_action;

    localparam logic [2:0] REG_NUM_LAYERS  = 3'd0;
    localparam logic [2:0] REG_SIZE0       = 3'd1;
    localparam logic [2:0] REG_SIZE1       = 3'd2;
    localparam logic [2:0] REG_SIZE2       = 3'd3;
    localparam logic [2:0] REG_SIZE3       = 3'd4;
    localparam logic [2:0] REG_CLAMP_LOW   = 3'd5;
    localparam logic [2:0] REG_CLAMP_HIGH  = 3'd6;
endpackage
`default_nettype wire

### design/mlp_dense_forward_pass_unit.sv
// Top level of the dense forward pass unit: command decode, sequencer, stores.
//
// Usage: a command transaction is taken when i_start is high and o_busy low.
// Commands write a weight, bias or activation (no result), start a run, or
// read one activation. A read gives one result, strobed by o_valid, after
// the memory read register, r_rd_pend, r_rd_pend2 and the output register.
// A run walks layers 1 to the last layer in use; each neuron goes through
// S_READ, S_MAC, S_BIAS and S_FIN using the single multiplier fed by the
// weight and activation memory read ports. It then streams the last layer,
// one result per cycle, with o_last on the final one. o_busy stays high
// until the last result is shown. Configuration is written on its own
// valid/ready channel while idle and no command is offered.
// Reset returns the sequencer to idle and configuration to its defaults;
// memories hold garbage until written. The receiver cannot stall: each
// result is present for one cycle.
`default_nettype none
module mlp_dense_forward_pass_unit
    import mlpd_pkg::*;
#(
    parameter int MAX_LAYERS  = MAX_LAYERS_DEF,
    parameter int MAX_NEURONS = MAX_NEURONS_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic [2:0]  i_action,
    input  wire logic [1:0]  i_layer,
    input  wire logic [5:0]  i_neuron,
    input  wire logic [5:0]  i_source,
    input  wire logic signed [15:0] i_value,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    output logic             o_valid,
    output logic [5:0]       o_neuron_index,
    output logic signed [15:0] o_activation_out,
    output logic             o_last
);
    localparam int LCAP = (MAX_LAYERS < 4) ? MAX_LAYERS : 4;
    localparam int NCAP = (MAX_NEURONS < 64) ? MAX_NEURONS : 64;
    localparam int LW   = $clog2(MAX_LAYERS);
    localparam int NW   = (MAX_NEURONS > 1) ? $clog2(MAX_NEURONS) : 1;
    localparam int AD   = MAX_LAYERS * MAX_NEURONS;
    localparam int AAW  = LW + NW;
    localparam int WD   = (MAX_LAYERS - 1) * MAX_NEURONS * MAX_NEURONS;
    localparam int WAW  = $clog2(WD);

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_MAC, S_BIAS, S_FIN, S_EMIT
    } t_state;

    t_state r_state;
    logic [2:0] r_num_layers;
    logic [6:0] r_size [4];
    logic signed [15:0] r_clamp_low, r_clamp_high;

    logic [2:0] r_l;           // current layer
    logic [6:0] r_n;           // neuron counter
    logic [6:0] r_s;           // source counter (issue)
    logic [2:0] r_pipe;        // mul / acc pipeline valid bits
    logic       r_rd_pend, r_rd_pend2;
    logic       r_rd_last, r_rd_last2;
    logic [5:0] r_rd_idx, r_rd_idx2;
    logic       r_rd_zero, r_rd_zero2;
    logic [15:0] r_rd_data;

    logic [2:0] eff_lc;
    logic [6:0] eff_sz [4];
    always_comb begin
        eff_lc = r_num_layers;
        if (eff_lc == 3'd0) eff_lc = 3'd1;
        if (eff_lc > 3'(LCAP)) eff_lc = 3'(LCAP);
        for (int i = 0; i < 4; i++) begin
            eff_sz[i] = r_size[i];
            if (eff_sz[i] == 7'd0) eff_sz[i] = 7'd1;
            if (eff_sz[i] > 7'(NCAP)) eff_sz[i] = 7'(NCAP);
        end
    end

    wire accept = i_start && !o_busy;
    wire addr_ok = (32'(i_layer) < MAX_LAYERS) && (32'(i_neuron) < MAX_NEURONS);
    wire src_ok  = 32'(i_source) < MAX_NEURONS;

    // memory ports
    logic           w_we, b_we, a_we;
    logic [WAW-1:0] w_waddr, w_raddr;
    logic [AAW-1:0] b_waddr, b_raddr, a_waddr, a_raddr;
    logic [15:0]    a_wdata, w_rdata, b_rdata, a_rdata;
    logic signed [15:0] mac_res;

    mlpd_mem #(.DEPTH(WD), .AW(WAW), .DW(16)) u_wmem (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(i_value),
        .i_raddr(w_raddr), .o_rdata(w_rdata));
    mlpd_mem #(.DEPTH(AD), .AW(AAW), .DW(16)) u_bmem (
        .i_clk(i_clk), .i_we(b_we), .i_waddr(b_waddr), .i_wdata(i_value),
        .i_raddr(b_raddr), .o_rdata(b_rdata));
    mlpd_mem #(.DEPTH(AD), .AW(AAW), .DW(16)) u_amem (
        .i_clk(i_clk), .i_we(a_we), .i_waddr(a_waddr), .i_wdata(a_wdata),
        .i_raddr(a_raddr), .o_rdata(a_rdata));

    logic [WAW-1:0] wr_w_addr, rd_w_addr;
    always_comb begin
        wr_w_addr = WAW'(((32'(i_layer) - 1) * MAX_NEURONS + 32'(i_neuron))
                         * MAX_NEURONS + 32'(i_source));
        rd_w_addr = WAW'(((32'(r_l) - 1) * MAX_NEURONS + 32'(r_n[5:0]))
                         * MAX_NEURONS + 32'(r_s[5:0]));
    end

    wire in_wr = accept && (i_action == ACT_WR_WEIGHT) && addr_ok && src_ok
                 && (i_layer != 2'd0);
    wire mac_issue = (r_state == S_MAC) && (r_s < eff_sz[r_l[1:0] - 2'd1]);

    always_comb begin
        w_we    = in_wr;
        w_waddr = wr_w_addr;
        w_raddr = rd_w_addr;
        b_we    = accept && (i_action == ACT_WR_BIAS) && addr_ok;
        b_waddr = AAW'(32'(i_layer) * MAX_NEURONS + 32'(i_neuron));
        b_raddr = AAW'(32'(r_l) * MAX_NEURONS + 32'(r_n[5:0]));
        a_we    = accept && (i_action == ACT_WR_ACT) && addr_ok;
        a_waddr = b_waddr;
        a_wdata = i_value;
        a_raddr = AAW'((32'(r_l) - 1) * MAX_NEURONS + 32'(r_s[5:0]));
        if (r_state == S_FIN) begin
            a_we    = 1'b1;
            a_waddr = b_raddr;
            a_wdata = mac_res;
        end
        if (r_state == S_IDLE) begin
            a_raddr = b_waddr;
        end
        if (r_state == S_EMIT) begin
            a_raddr = AAW'(32'(r_l) * MAX_NEURONS + 32'(r_n[5:0]));
        end
    end

    mlpd_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
        .i_clk(i_clk),
        .i_clear(r_state == S_READ),
        .i_mul_en(r_pipe[0]),
        .i_act(a_rdata), .i_wgt(w_rdata),
        .i_acc_en(r_pipe[1]),
        .i_bias_en(r_state == S_BIAS && r_pipe == 3'd0),
        .i_bias(b_rdata),
        .i_clamp_low(r_clamp_low), .i_clamp_high(r_clamp_high),
        .o_result(mac_res));

    wire emit_issue = (r_state == S_EMIT) && (r_n < eff_sz[r_l[1:0]]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_num_layers  <= 3'd2;
            for (int i = 0; i < 4; i++) r_size[i] <= 7'd64;
            r_clamp_low   <= 16'sd0;
            r_clamp_high  <= 16'sd256;
            r_pipe        <= '0;
            r_rd_pend     <= 1'b0;
            r_rd_pend2    <= 1'b0;
            o_valid       <= 1'b0;
            o_busy        <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_NUM_LAYERS:  r_num_layers  <= i_cfg_data[2:0];
                    REG_CLAMP_LOW:   r_clamp_low   <= i_cfg_data;
                    REG_CLAMP_HIGH:  r_clamp_high  <= i_cfg_data;
                    default: begin
                        if (i_cfg_index inside {[REG_SIZE0:REG_SIZE3]})
                            r_size[2'(i_cfg_index - REG_SIZE0)] <= i_cfg_data[6:0];
                    end
                endcase
            end
            r_pipe     <= {r_pipe[1:0], mac_issue};
            r_rd_pend2 <= r_rd_pend;
            r_rd_last2 <= r_rd_last;
            r_rd_idx2  <= r_rd_idx;
            r_rd_zero2 <= r_rd_zero;
            r_rd_data  <= a_rdata;
            r_rd_pend  <= 1'b0;
            o_valid    <= r_rd_pend2;
            o_last     <= r_rd_last2;
            o_neuron_index   <= r_rd_idx2;
            o_activation_out <= r_rd_zero2 ? 16'sd0 : r_rd_data;
            case (r_state)
                S_IDLE: begin
                    if (accept && i_action == ACT_READ) begin
                        r_rd_pend <= 1'b1;
                        r_rd_last <= 1'b1;
                        r_rd_idx  <= i_neuron;
                        r_rd_zero <= !addr_ok;
                        o_busy    <= 1'b1;
                        r_state   <= S_EMIT;
                        r_l       <= 3'd0;
                        r_n       <= 7'd64;
                    end else if (accept && i_action == ACT_RUN) begin
                        o_busy <= 1'b1;
                        r_l    <= 3'd1;
                        r_n    <= 7'd0;
                        r_s    <= 7'd0;
                        if (eff_lc == 3'd1) begin
                            r_l <= 3'd0;
                            r_state <= S_EMIT;
                        end else begin
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    r_s     <= 7'd0;
                    r_state <= S_MAC;
                end
                S_MAC: begin
                    if (mac_issue) begin
                        r_s <= r_s + 7'd1;
                    end else if (r_pipe == 3'd0) begin
                        r_state <= S_BIAS;
                    end
                end
                S_BIAS: begin
                    if (r_pipe == 3'd0) r_state <= S_FIN;
                end
                S_FIN: begin
                    r_state <= S_READ;
                    if (r_n + 7'd1 < eff_sz[r_l[1:0]]) begin
                        r_n <= r_n + 7'd1;
                    end else begin
                        r_n <= 7'd0;
                        if (r_l + 3'd1 < eff_lc) begin
                            r_l <= r_l + 3'd1;
                        end else begin
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_EMIT: begin
                    if (emit_issue) begin
                        r_rd_pend <= 1'b1;
                        r_rd_last <= (r_n + 7'd1 == eff_sz[r_l[1:0]]);
                        r_rd_idx  <= r_n[5:0];
                        r_rd_zero <= 1'b0;
                        r_n       <= r_n + 7'd1;
                    end else if (!r_rd_pend && !r_rd_pend2 && !o_valid) begin
                        r_state <= S_IDLE;
                        o_busy  <= 1'b0;
                    end else if (!r_rd_pend && !r_rd_pend2) begin
                        r_state <= S_IDLE;
                        o_busy  <= 1'b0;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_cfg_ready = !o_busy && !i_start;
endmodule
`default_nettype wire

### design/mlpd_mem.sv
// Synchronous single-port-write, single-read memory with registered read data.
`default_nettype none
module mlpd_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int DW    = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### design/mlpd_mac.sv
// Multiply-accumulate with bias, rescale and clamp for one neuron.
`default_nettype none
module mlpd_mac
    import mlpd_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_clear,
    input  wire logic                    i_mul_en,
    input  wire logic signed [VAL_W-1:0] i_act,
    input  wire logic signed [VAL_W-1:0] i_wgt,
    input  wire logic                    i_acc_en,
    input  wire logic                    i_bias_en,
    input  wire logic signed [VAL_W-1:0] i_bias,
    input  wire logic signed [VAL_W-1:0] i_clamp_low,
    input  wire logic signed [VAL_W-1:0] i_clamp_high,
    output logic signed [VAL_W-1:0]      o_result
);
    logic signed [2*VAL_W-1:0] r_prod;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [ACC_W-1:0]   shifted;
    logic signed [ACC_W-1:0]   lo_ext;
    logic signed [ACC_W-1:0]   hi_ext;
    logic signed [ACC_W-1:0]   q;

    always_ff @(posedge i_clk) begin
        if (i_mul_en) begin
            r_prod <= i_act * i_wgt;
        end
        if (i_clear) begin
            r_acc <= '0;
        end else if (i_acc_en) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end else if (i_bias_en) begin
            r_acc <= r_acc + (ACC_W'(i_bias) <<< FRAC_BITS);
        end
    end

    always_comb begin
        shifted = r_acc >>> FRAC_BITS;
        lo_ext  = ACC_W'(i_clamp_low);
        hi_ext  = ACC_W'(i_clamp_high);
        q       = shifted;
        if (q < lo_ext) q = lo_ext;
        if (q > hi_ext) q = hi_ext;
        o_result = q[VAL_W-1:0];
    end
endmodule
`default_nettype wire

### design/mlpd_checker.sv
// Port-level assertions for the dense forward pass unit, bound to the top level.
`default_nettype none
module mlpd_checker
    import mlpd_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_start,
    input wire logic [2:0] i_action,
    input wire logic       o_busy,
    input wire logic       o_valid,
    input wire logic       o_last,
    input wire logic       o_cfg_ready
);
    a_last_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last && o_valid |-> o_busy || $past(o_busy)) else $error("last outside run");
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready |-> !o_busy) else $error("cfg ready while busy");
    a_cmd_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy && (i_action == ACT_RUN || i_action == ACT_READ) |=> o_busy)
        else $error("run or read did not raise busy");
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_busy) else $error("result while idle");
    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |=> !o_valid) else $error("result after last");
endmodule

bind mlp_dense_forward_pass_unit mlpd_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_action(i_action),
    .o_busy(o_busy), .o_valid(o_valid), .o_last(o_last), .o_cfg_ready(o_cfg_ready));
`default_nettype wire
